// File: src/multicore_round_robin_task_picker_top_defines.svh
// Assertion macros for the round-robin task picker.
`ifndef MULTICORE_ROUND_ROBIN_TASK_PICKER_TOP_DEFINES_SVH
`define MULTICORE_ROUND_ROBIN_TASK_PICKER_TOP_DEFINES_SVH

`ifndef SYNTH

`define MRRTP_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("invariant violated");

`define MRRTP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication violated");

`define MRRTP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`else

`define MRRTP_ASSERT_ALWAYS(lbl, cond)
`define MRRTP_ASSERT_IMP(lbl, ante, cons)
`define MRRTP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: src/mrrtp_pkg.sv
// Shared constants, codes and controller/datapath interface types.
package mrrtp_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int CPU_COUNT   = 8;
	localparam int HANDLE_BITS = 8;

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int CPU_W = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;

	// Field widths on the ports
	localparam int REQ_W    = 2;
	localparam int CPU_ID_W = 3;
	localparam int HANDLE_W = 8;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;
	localparam int S_DATA_W = 16;
	localparam int M_DATA_W = 16;

	typedef enum logic [REQ_W-1:0] {
		REQ_SWITCH = 2'd0,
		REQ_CREATE = 2'd1,
		REQ_REMOVE = 2'd2
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_NOT_FOUND = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_IDLE = 2'd1,
		KIND_TASK = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_RELEASE,
		ST_SCAN,
		ST_CREATE,
		ST_RM_SRCH,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic latch;
		logic release_prev;
		logic wrap;
		logic step;
		logic pick_task;
		logic pick_idle;
		logic create;
		logic srch_inc;
		logic not_found;
		logic remove;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic [REQ_W-1:0] req;
		logic             cpu_ok;
		logic             count_zero;
		logic             idx_ge_count;
		logic             entry_busy;
		logic             rem_last;
		logic             match;
		logic             out_free;
	} stat_t;

endpackage

// File: src/mrrtp_dpath.sv
// Datapath: task table lanes, busy bits, per-cpu state and the result register.
`include "multicore_round_robin_task_picker_top_defines.svh"

module mrrtp_dpath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  mrrtp_pkg::cmd_t                    cmd,
	output mrrtp_pkg::stat_t                   st,
	input  logic [mrrtp_pkg::REQ_W-1:0]        in_req,
	input  logic [mrrtp_pkg::CPU_ID_W-1:0]     in_cpu,
	input  logic [mrrtp_pkg::HANDLE_W-1:0]     in_handle,
	input  logic                               m_tready,
	output logic                               m_tvalid,
	output logic [mrrtp_pkg::M_DATA_W-1:0]     m_tdata,
	output logic                               m_tuser
);

	logic [mrrtp_pkg::REQ_W-1:0]       req_q;
	logic [mrrtp_pkg::CPU_ID_W-1:0]    cpu_q;
	logic [mrrtp_pkg::HANDLE_BITS-1:0] h_q;

	logic [mrrtp_pkg::HANDLE_BITS-1:0] table_q [mrrtp_pkg::TABLE_DEPTH];
	logic [mrrtp_pkg::TABLE_DEPTH-1:0] busy_q;
	logic [mrrtp_pkg::TABLE_DEPTH-1:0] busy_nxt;
	logic [mrrtp_pkg::CNT_W-1:0]       count_q;
	logic [mrrtp_pkg::CNT_W-1:0]       idx_q;
	logic [mrrtp_pkg::CNT_W-1:0]       rem_q;

	logic [mrrtp_pkg::CNT_W-1:0]       cursor_q    [mrrtp_pkg::CPU_COUNT];
	mrrtp_pkg::kind_t                  cur_kind_q  [mrrtp_pkg::CPU_COUNT];
	mrrtp_pkg::kind_t                  prev_kind_q [mrrtp_pkg::CPU_COUNT];
	logic [mrrtp_pkg::HANDLE_BITS-1:0] cur_h_q     [mrrtp_pkg::CPU_COUNT];
	logic [mrrtp_pkg::HANDLE_BITS-1:0] prev_h_q    [mrrtp_pkg::CPU_COUNT];

	logic [mrrtp_pkg::HANDLE_W-1:0]    res_next_q;
	logic                              res_idle_q;
	mrrtp_pkg::status_t                res_status_q;

	logic                              m_tvalid_q;
	logic [mrrtp_pkg::M_DATA_W-1:0]    out_data_q;
	logic                              out_user_q;

	logic [mrrtp_pkg::CPU_W-1:0]       cpu_sel;
	logic [mrrtp_pkg::HANDLE_BITS-1:0] rd_h;
	logic                              full;
	mrrtp_pkg::kind_t                  cur_kind;
	mrrtp_pkg::kind_t                  prev_kind;
	logic [mrrtp_pkg::HANDLE_BITS-1:0] prev_h;

	assign cpu_sel   = cpu_q[mrrtp_pkg::CPU_W-1:0];
	// Indexed table read port, shared by the scan and the remove search
	assign rd_h      = table_q[idx_q[mrrtp_pkg::IDX_W-1:0]];
	assign full      = count_q >= mrrtp_pkg::CNT_W'(mrrtp_pkg::TABLE_DEPTH);
	assign cur_kind  = cur_kind_q[cpu_sel];
	assign prev_kind = prev_kind_q[cpu_sel];
	assign prev_h    = prev_h_q[cpu_sel];

	always_comb begin
		st.req          = req_q;
		st.cpu_ok       = int'(cpu_q) < mrrtp_pkg::CPU_COUNT;
		st.count_zero   = count_q == '0;
		st.idx_ge_count = idx_q >= count_q;
		st.entry_busy   = busy_q[idx_q[mrrtp_pkg::IDX_W-1:0]];
		st.rem_last     = rem_q == mrrtp_pkg::CNT_W'(1);
		st.match        = rd_h == h_q;
		st.out_free     = !m_tvalid_q || m_tready;
	end

	// Busy bits follow the handle: release, pick and create write all live entries holding it; remove shifts them down
	always_comb begin
		busy_nxt = busy_q;
		for (int i = 0; i < mrrtp_pkg::TABLE_DEPTH; i++) begin
			if (cmd.release_prev && prev_kind == mrrtp_pkg::KIND_TASK &&
					mrrtp_pkg::CNT_W'(i) < count_q && table_q[i] == prev_h)
				busy_nxt[i] = 1'b0;
			if (cmd.pick_task && mrrtp_pkg::CNT_W'(i) < count_q && table_q[i] == rd_h)
				busy_nxt[i] = 1'b1;
			if (cmd.create && !full) begin
				if (mrrtp_pkg::CNT_W'(i) < count_q && table_q[i] == h_q)
					busy_nxt[i] = 1'b0;
				if (mrrtp_pkg::CNT_W'(i) == count_q)
					busy_nxt[i] = 1'b0;
			end
		end
		if (cmd.remove) begin
			for (int i = 0; i < mrrtp_pkg::TABLE_DEPTH - 1; i++) begin
				if (mrrtp_pkg::CNT_W'(i) >= idx_q && mrrtp_pkg::CNT_W'(i + 1) < count_q)
					busy_nxt[i] = busy_q[i + 1];
			end
			for (int i = 0; i < mrrtp_pkg::TABLE_DEPTH; i++) begin
				if (mrrtp_pkg::CNT_W'(i + 1) == count_q)
					busy_nxt[i] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= '0;
			count_q      <= '0;
			idx_q        <= '0;
			rem_q        <= '0;
			res_next_q   <= '0;
			res_idle_q   <= 1'b0;
			res_status_q <= mrrtp_pkg::STAT_OK;
			m_tvalid_q   <= 1'b0;
			for (int c = 0; c < mrrtp_pkg::CPU_COUNT; c++) begin
				cursor_q[c]    <= '0;
				cur_kind_q[c]  <= mrrtp_pkg::KIND_NONE;
				prev_kind_q[c] <= mrrtp_pkg::KIND_NONE;
			end
		end else begin
			busy_q <= busy_nxt;
			if (cmd.latch) begin
				idx_q        <= '0;
				res_next_q   <= '0;
				res_idle_q   <= 1'b0;
				res_status_q <= mrrtp_pkg::STAT_OK;
			end
			if (cmd.release_prev) begin
				idx_q <= cursor_q[cpu_sel];
				rem_q <= count_q;
				// A cpu that never ran anything counts as running its idle task
				prev_kind_q[cpu_sel] <= (cur_kind == mrrtp_pkg::KIND_NONE) ?
					mrrtp_pkg::KIND_IDLE : cur_kind;
			end
			if (cmd.wrap)
				idx_q <= idx_q - count_q;
			if (cmd.step) begin
				cursor_q[cpu_sel] <= idx_q + mrrtp_pkg::CNT_W'(1);
				idx_q             <= idx_q + mrrtp_pkg::CNT_W'(1);
				rem_q             <= rem_q - mrrtp_pkg::CNT_W'(1);
			end
			if (cmd.pick_task) begin
				cursor_q[cpu_sel]   <= idx_q + mrrtp_pkg::CNT_W'(1);
				cur_kind_q[cpu_sel] <= mrrtp_pkg::KIND_TASK;
				res_next_q          <= mrrtp_pkg::HANDLE_W'(rd_h);
			end
			if (cmd.pick_idle) begin
				cur_kind_q[cpu_sel] <= mrrtp_pkg::KIND_IDLE;
				res_idle_q          <= 1'b1;
			end
			if (cmd.create) begin
				if (full)
					res_status_q <= mrrtp_pkg::STAT_FULL;
				else
					count_q <= count_q + mrrtp_pkg::CNT_W'(1);
			end
			if (cmd.srch_inc)
				idx_q <= idx_q + mrrtp_pkg::CNT_W'(1);
			if (cmd.not_found)
				res_status_q <= mrrtp_pkg::STAT_NOT_FOUND;
			if (cmd.remove)
				count_q <= count_q - mrrtp_pkg::CNT_W'(1);
			if (cmd.load_out)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q <= in_req;
			cpu_q <= in_cpu;
			h_q   <= in_handle[mrrtp_pkg::HANDLE_BITS-1:0];
		end
		if (cmd.release_prev)
			prev_h_q[cpu_sel] <= cur_h_q[cpu_sel];
		if (cmd.pick_task)
			cur_h_q[cpu_sel] <= rd_h;
		if (cmd.create && !full)
			table_q[count_q[mrrtp_pkg::IDX_W-1:0]] <= h_q;
		if (cmd.remove) begin
			// Close the gap: shift every entry above the hit down by one
			for (int i = 0; i < mrrtp_pkg::TABLE_DEPTH - 1; i++) begin
				if (mrrtp_pkg::CNT_W'(i) >= idx_q && mrrtp_pkg::CNT_W'(i + 1) < count_q)
					table_q[i] <= table_q[i + 1];
			end
		end
		if (cmd.load_out) begin
			out_data_q <= {1'b0, mrrtp_pkg::COUNT_W'(count_q), res_status_q, res_next_q};
			out_user_q <= res_idle_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	`MRRTP_ASSERT_ALWAYS(a_count_bound, count_q <= mrrtp_pkg::CNT_W'(mrrtp_pkg::TABLE_DEPTH))
	`MRRTP_ASSERT_NEXT(a_create_grows, cmd.create && !full, count_q == $past(count_q) + mrrtp_pkg::CNT_W'(1))
	`MRRTP_ASSERT_IMP(a_pick_in_table, cmd.pick_task, idx_q < count_q && !busy_q[idx_q[mrrtp_pkg::IDX_W-1:0]])

endmodule

// File: src/mrrtp_ctrl.sv
// Controller: sequences one request through release, scan, create or remove steps.
`include "multicore_round_robin_task_picker_top_defines.svh"

module mrrtp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  mrrtp_pkg::stat_t st,
	output mrrtp_pkg::cmd_t  cmd
);

	mrrtp_pkg::state_t state_q;
	mrrtp_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= mrrtp_pkg::ST_IDLE;
		else
			state_q <= state_nxt;
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			mrrtp_pkg::ST_IDLE: begin
				if (s_tvalid)
					state_nxt = mrrtp_pkg::ST_DISPATCH;
			end
			mrrtp_pkg::ST_DISPATCH: begin
				unique case (st.req)
					mrrtp_pkg::REQ_SWITCH:
						state_nxt = st.cpu_ok ? mrrtp_pkg::ST_RELEASE : mrrtp_pkg::ST_FINISH;
					mrrtp_pkg::REQ_CREATE: state_nxt = mrrtp_pkg::ST_CREATE;
					mrrtp_pkg::REQ_REMOVE: state_nxt = mrrtp_pkg::ST_RM_SRCH;
					default:               state_nxt = mrrtp_pkg::ST_FINISH;
				endcase
			end
			mrrtp_pkg::ST_RELEASE: state_nxt = mrrtp_pkg::ST_SCAN;
			mrrtp_pkg::ST_SCAN: begin
				if (st.count_zero)
					state_nxt = mrrtp_pkg::ST_FINISH;
				else if (!st.idx_ge_count && (!st.entry_busy || st.rem_last))
					state_nxt = mrrtp_pkg::ST_FINISH;
			end
			mrrtp_pkg::ST_CREATE: state_nxt = mrrtp_pkg::ST_FINISH;
			mrrtp_pkg::ST_RM_SRCH: begin
				if (st.idx_ge_count || st.match)
					state_nxt = mrrtp_pkg::ST_FINISH;
			end
			mrrtp_pkg::ST_FINISH: begin
				if (st.out_free)
					state_nxt = mrrtp_pkg::ST_IDLE;
			end
			default: state_nxt = mrrtp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			mrrtp_pkg::ST_IDLE: begin
				s_tready  = 1'b1;
				cmd.latch = s_tvalid;
			end
			mrrtp_pkg::ST_DISPATCH: ;
			mrrtp_pkg::ST_RELEASE: cmd.release_prev = 1'b1;
			mrrtp_pkg::ST_SCAN: begin
				if (st.count_zero) begin
					cmd.pick_idle = 1'b1;
				end else if (st.idx_ge_count) begin
					cmd.wrap = 1'b1;
				end else if (!st.entry_busy) begin
					cmd.pick_task = 1'b1;
				end else begin
					// Busy entry: advance, give up after a full lap
					cmd.step      = 1'b1;
					cmd.pick_idle = st.rem_last;
				end
			end
			mrrtp_pkg::ST_CREATE: cmd.create = 1'b1;
			mrrtp_pkg::ST_RM_SRCH: begin
				if (st.idx_ge_count)
					cmd.not_found = 1'b1;
				else if (st.match)
					cmd.remove = 1'b1;
				else
					cmd.srch_inc = 1'b1;
			end
			mrrtp_pkg::ST_FINISH: cmd.load_out = st.out_free;
			default: ;
		endcase
	end

	`MRRTP_ASSERT_NEXT(a_accept_dispatch, s_tvalid && s_tready, state_q == mrrtp_pkg::ST_DISPATCH)
	`MRRTP_ASSERT_IMP(a_load_free, cmd.load_out, st.out_free)

endmodule

// File: src/multicore_round_robin_task_picker_top.sv
// Round-robin task picker: one transaction in, one result transaction out.
// Each request is dispatched, then runs its own steps: create appends the handle unless the
// table is full; remove searches the table from the first entry for the handle and closes
// the gap; switch releases the previous task and scans from the cpu's cursor, wrapping past
// the end. One transaction is handled at a time; the serial table scan sets the rate. The
// next input transaction is taken while a finished result waits in the output register.
// arst_n clears the table count, busy bits, cursors and per-cpu task state at once.
module multicore_round_robin_task_picker_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [mrrtp_pkg::S_DATA_W-1:0] s_axis_tdata,  // cpu_id[2:0], task_handle[10:3]
	input  logic [mrrtp_pkg::REQ_W-1:0]    s_axis_tuser,  // req_type[1:0]
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [mrrtp_pkg::M_DATA_W-1:0] m_axis_tdata,  // next_handle[7:0], status[9:8],
	                                                      // task_count[14:10]
	output logic                           m_axis_tuser   // next_is_idle
);

	mrrtp_pkg::cmd_t  cmd;
	mrrtp_pkg::stat_t st;

	mrrtp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_tready (s_axis_tready),
		.st       (st),
		.cmd      (cmd)
	);

	mrrtp_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_req    (s_axis_tuser),
		.in_cpu    (s_axis_tdata[mrrtp_pkg::CPU_ID_W-1:0]),
		.in_handle (s_axis_tdata[mrrtp_pkg::CPU_ID_W +: mrrtp_pkg::HANDLE_W]),
		.m_tready  (m_axis_tready),
		.m_tvalid  (m_axis_tvalid),
		.m_tdata   (m_axis_tdata),
		.m_tuser   (m_axis_tuser)
	);

endmodule
